[src/field_centric_xdrive_mixer_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the field-centric X-drive mixer
// Implication checks in the same cycle and in the next cycle.
// ---------------------------------------------------------------------------
`ifndef FIELD_CENTRIC_XDRIVE_MIXER_ASSERT_SVH
`define FIELD_CENTRIC_XDRIVE_MIXER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FCXM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fcxm same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define FCXM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fcxm next-cycle check failed");

`endif

[src/fcxm_pkg.sv]
// ---------------------------------------------------------------------------
// fcxm_pkg
// Types, constants and curve tables shared by the X-drive mixer modules.
// ---------------------------------------------------------------------------
package fcxm_pkg;

    localparam int CURVE_W        = 24;
    localparam int IQ             = 16;
    localparam int CORDIC_STEPS   = 16;
    localparam int CORDIC_PER_CYC = 4;
    localparam int STEP_W         = $clog2(CORDIC_STEPS / CORDIC_PER_CYC);
    localparam int SHIFT_W        = $clog2(CORDIC_STEPS);
    localparam int VEC_W          = 28;
    localparam int ANG_W          = 26;
    localparam int PROD_W         = VEC_W + 17;
    localparam int WHEEL_W        = 30;
    localparam int QUOT_W         = 26;
    localparam int DIV_PER_CYC    = 2;
    localparam int DIV_CYCLES     = QUOT_W / DIV_PER_CYC;
    localparam int DIV_CNT_W      = $clog2(DIV_CYCLES);
    localparam int DIV_W          = WHEEL_W + IQ + QUOT_W;
    localparam int CURVE_DIV_XY   = 100;
    localparam int CURVE_DIV_TURN = 50;
    localparam int HEAD_TURN      = 36000;
    localparam int HEAD_HALF      = 18000;
    localparam int HEAD_QUARTER   = 9000;

    localparam logic signed [16:0] ROT_SCALE = 17'sd28141;

    localparam logic signed [ANG_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        26'sd1152000, 26'sd680065, 26'sd359328, 26'sd182400,
        26'sd91554,   26'sd45822,  26'sd22916,  26'sd11459,
        26'sd5730,    26'sd2865,   26'sd1432,   26'sd716,
        26'sd358,     26'sd179,    26'sd90,     26'sd45
    };

    typedef struct packed {
        logic signed [7:0]  strafe_axis;
        logic signed [7:0]  forward_axis;
        logic signed [7:0]  turn_axis;
        logic        [15:0] heading_centideg;
    } t_in;

    typedef struct packed {
        logic signed [15:0] front_left_speed;
        logic signed [15:0] back_left_speed;
        logic signed [15:0] front_right_speed;
        logic signed [15:0] back_right_speed;
    } t_out;

    // One classified item: curved axes, reduced angle and half-turn flag.
    typedef struct packed {
        logic signed [CURVE_W:0]  jx;
        logic signed [CURVE_W:0]  jy;
        logic signed [CURVE_W:0]  jz;
        logic signed [ANG_W-1:0]  z;
        logic                     flip;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic idle;
        logic pop;
    } t_back_status;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_ROT,
        BK_SCALE,
        BK_MIX,
        BK_MUL,
        BK_DIV
    } t_back_state;

    typedef logic [CURVE_W-1:0] t_xy_tab   [129];
    typedef logic [CURVE_W-1:0] t_turn_tab [65];

    function automatic logic [63:0] f_isqrt(logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        x = x_in;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        for (int k = 0; k < 32; k++) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic t_xy_tab f_build_xy();
        t_xy_tab     tab;
        logic [63:0] cube;
        logic [63:0] root;
        for (int a = 0; a < 129; a++) begin
            cube   = 64'(a * a * a);
            root   = f_isqrt((cube << 32) / CURVE_DIV_XY);
            tab[a] = root[CURVE_W-1:0];
        end
        return tab;
    endfunction

    function automatic t_turn_tab f_build_turn();
        t_turn_tab   tab;
        logic [63:0] cube;
        logic [63:0] root;
        for (int a = 0; a < 65; a++) begin
            cube   = 64'(a * a * a);
            root   = f_isqrt((cube << 32) / CURVE_DIV_TURN);
            tab[a] = root[CURVE_W-1:0];
        end
        return tab;
    endfunction

    localparam t_xy_tab   CURVE_XY_TAB   = f_build_xy();
    localparam t_turn_tab CURVE_TURN_TAB = f_build_turn();

endpackage

[src/fcxm_front.sv]
// ---------------------------------------------------------------------------
// fcxm_front
// Applies the stick curves and folds the heading into the CORDIC range.
// ---------------------------------------------------------------------------
module fcxm_front (
    input  fcxm_pkg::t_in  i_item,
    output fcxm_pkg::t_job o_job
);
    import fcxm_pkg::*;

    logic signed [8:0]  s_ext;
    logic signed [8:0]  f_ext;
    logic signed [8:0]  t_half;
    logic        [7:0]  s_mag;
    logic        [7:0]  f_mag;
    logic        [6:0]  t_mag;
    logic signed [17:0] g;
    logic               flip;

    always_comb begin
        s_ext  = 9'(i_item.strafe_axis);
        f_ext  = 9'(i_item.forward_axis);
        // Halve the turn axis, truncating toward zero.
        t_half = $signed(9'(i_item.turn_axis) + 9'(i_item.turn_axis < 0)) >>> 1;
        s_mag  = s_ext < 0 ? 8'(-s_ext) : 8'(s_ext);
        f_mag  = f_ext < 0 ? 8'(-f_ext) : 8'(f_ext);
        t_mag  = t_half < 0 ? 7'(-t_half) : 7'(t_half);

        // Strafe is negated before curving.
        o_job.jx = s_ext > 0 ? -$signed({1'b0, CURVE_XY_TAB[s_mag]})
                             :  $signed({1'b0, CURVE_XY_TAB[s_mag]});
        o_job.jy = f_ext < 0 ? -$signed({1'b0, CURVE_XY_TAB[f_mag]})
                             :  $signed({1'b0, CURVE_XY_TAB[f_mag]});
        o_job.jz = t_half < 0 ? -$signed({1'b0, CURVE_TURN_TAB[t_mag]})
                              :  $signed({1'b0, CURVE_TURN_TAB[t_mag]});

        g = $signed({2'b00, i_item.heading_centideg});
        if (g >= 18'(HEAD_TURN)) begin
            g = g - 18'(HEAD_TURN);
        end
        if (g > 18'(HEAD_HALF)) begin
            g = g - 18'(HEAD_TURN);
        end
        flip = 1'b0;
        if (g > 18'(HEAD_QUARTER)) begin
            flip = 1'b1;
            g    = g - 18'(HEAD_HALF);
        end else if (g < -18'(HEAD_QUARTER)) begin
            flip = 1'b1;
            g    = g + 18'(HEAD_HALF);
        end
        o_job.flip = flip;
        o_job.z    = ANG_W'(g) <<< 8;
    end

endmodule

[src/fcxm_queue.sv]
// ---------------------------------------------------------------------------
// fcxm_queue
// Two-entry queue of classified items between front and back.
// ---------------------------------------------------------------------------
module fcxm_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  fcxm_pkg::t_job     i_job,
    input  logic               i_pop,
    output fcxm_pkg::t_job     o_job,
    output fcxm_pkg::t_q_status o_status
);
    import fcxm_pkg::*;

    t_job       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    always_comb begin
        n_count = r_count + 2'(i_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    assign o_job          = r_mem[r_rd_ptr];
    assign o_status.full  = r_count[1];
    assign o_status.empty = (r_count == 2'd0);

endmodule

[src/fcxm_back.sv]
// ---------------------------------------------------------------------------
// fcxm_back
// Rotates, mixes and scales one item at a time into four wheel speeds.
// ---------------------------------------------------------------------------
module fcxm_back #(
    parameter int FRAC_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fcxm_pkg::t_q_status   i_q_status,
    input  fcxm_pkg::t_job        i_job,
    output fcxm_pkg::t_back_status o_status,
    output logic                  o_strobe,
    output fcxm_pkg::t_out        o_result
);
    import fcxm_pkg::*;

    localparam int D_SHIFT = IQ - FRAC_BITS;

    t_back_state r_state, n_state;
    logic [STEP_W-1:0]      r_step, n_step;
    logic [DIV_CNT_W-1:0]   r_cnt, n_cnt;
    logic signed [VEC_W-1:0]  r_u, n_u, r_v, n_v;
    logic signed [ANG_W-1:0]  r_z, n_z;
    logic signed [CURVE_W:0]  r_jz, n_jz;
    logic [CURVE_W-1:0]       r_max_axis, n_max_axis;
    logic signed [PROD_W-1:0] r_pu, n_pu, r_pv, n_pv;
    logic [WHEEL_W-1:0]       r_absw [4];
    logic [WHEEL_W-1:0]       n_absw [4];
    logic                     r_negw [4];
    logic                     n_negw [4];
    logic [WHEEL_W-1:0]       r_max_out, n_max_out;
    logic [DIV_W-1:0]         r_rem [4];
    logic [DIV_W-1:0]         n_rem [4];
    logic [QUOT_W-1:0]        r_quot [4];
    logic [QUOT_W-1:0]        n_quot [4];
    logic [DIV_W-1:0]         r_den, n_den;
    logic                     r_zero, n_zero;
    logic                     r_strobe, n_strobe;
    t_out                     r_out, n_out;

    logic signed [VEC_W-1:0]   u_t, v_t, du, dv, x2, y2;
    logic signed [ANG_W-1:0]   z_t;
    logic [SHIFT_W-1:0]        sh;
    logic signed [WHEEL_W-1:0] w [4];
    logic [CURVE_W-1:0]        ax, ay, az;
    logic [DIV_W-1:0]          d_full, den_t, rem_t;
    logic [QUOT_W-1:0]         q_t;
    logic signed [15:0]        spd [4];
    logic                      pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BK_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step     <= n_step;
        r_cnt      <= n_cnt;
        r_u        <= n_u;
        r_v        <= n_v;
        r_z        <= n_z;
        r_jz       <= n_jz;
        r_max_axis <= n_max_axis;
        r_pu       <= n_pu;
        r_pv       <= n_pv;
        r_absw     <= n_absw;
        r_negw     <= n_negw;
        r_max_out  <= n_max_out;
        r_rem      <= n_rem;
        r_quot     <= n_quot;
        r_den      <= n_den;
        r_zero     <= n_zero;
        r_out      <= n_out;
    end

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_cnt      = r_cnt;
        n_u        = r_u;
        n_v        = r_v;
        n_z        = r_z;
        n_jz       = r_jz;
        n_max_axis = r_max_axis;
        n_pu       = r_pu;
        n_pv       = r_pv;
        n_absw     = r_absw;
        n_negw     = r_negw;
        n_max_out  = r_max_out;
        n_rem      = r_rem;
        n_quot     = r_quot;
        n_den      = r_den;
        n_zero     = r_zero;
        n_out      = r_out;
        n_strobe   = 1'b0;
        pop        = 1'b0;
        u_t = r_u;
        v_t = r_v;
        z_t = r_z;
        du  = '0;
        dv  = '0;
        sh  = '0;
        x2  = '0;
        y2  = '0;
        w   = '{default: '0};
        ax  = '0;
        ay  = '0;
        az  = '0;
        d_full = '0;
        den_t  = '0;
        rem_t  = '0;
        q_t    = '0;
        spd    = '{default: '0};

        unique case (r_state)
            BK_IDLE: begin
                if (!i_q_status.empty) begin
                    pop = 1'b1;
                    n_u = i_job.flip ? -VEC_W'(i_job.jy) : VEC_W'(i_job.jy);
                    n_v = i_job.flip ? -VEC_W'(i_job.jx) : VEC_W'(i_job.jx);
                    n_z = i_job.z;
                    n_jz = i_job.jz;
                    ax = i_job.jx < 0 ? CURVE_W'(-i_job.jx) : CURVE_W'(i_job.jx);
                    ay = i_job.jy < 0 ? CURVE_W'(-i_job.jy) : CURVE_W'(i_job.jy);
                    az = i_job.jz < 0 ? CURVE_W'(-i_job.jz) : CURVE_W'(i_job.jz);
                    n_max_axis = ax;
                    if (ay > n_max_axis) begin
                        n_max_axis = ay;
                    end
                    if (az > n_max_axis) begin
                        n_max_axis = az;
                    end
                    n_step  = '0;
                    n_state = BK_ROT;
                end
            end
            BK_ROT: begin
                for (int k = 0; k < CORDIC_PER_CYC; k++) begin
                    sh = SHIFT_W'(int'(r_step) * CORDIC_PER_CYC + k);
                    du = v_t >>> sh;
                    dv = u_t >>> sh;
                    if (z_t >= 0) begin
                        u_t = u_t - du;
                        v_t = v_t + dv;
                        z_t = z_t - ATAN_TAB[sh];
                    end else begin
                        u_t = u_t + du;
                        v_t = v_t - dv;
                        z_t = z_t + ATAN_TAB[sh];
                    end
                end
                n_u    = u_t;
                n_v    = v_t;
                n_z    = z_t;
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(CORDIC_STEPS / CORDIC_PER_CYC - 1)) begin
                    n_state = BK_SCALE;
                end
            end
            BK_SCALE: begin
                n_pu    = PROD_W'(r_u) * PROD_W'(ROT_SCALE);
                n_pv    = PROD_W'(r_v) * PROD_W'(ROT_SCALE);
                n_state = BK_MIX;
            end
            BK_MIX: begin
                x2 = VEC_W'((r_pu + PROD_W'(32768)) >>> IQ);
                y2 = VEC_W'((r_pv + PROD_W'(32768)) >>> IQ);
                w[0] = WHEEL_W'(x2) - WHEEL_W'(y2) + WHEEL_W'(r_jz);
                w[1] = WHEEL_W'(x2) + WHEEL_W'(y2) + WHEEL_W'(r_jz);
                w[2] = -WHEEL_W'(x2) - WHEEL_W'(y2) + WHEEL_W'(r_jz);
                w[3] = -WHEEL_W'(x2) + WHEEL_W'(y2) + WHEEL_W'(r_jz);
                n_max_out = '0;
                for (int i = 0; i < 4; i++) begin
                    n_negw[i] = w[i] < 0;
                    n_absw[i] = w[i] < 0 ? WHEEL_W'(-w[i]) : WHEEL_W'(w[i]);
                    if (n_absw[i] > n_max_out) begin
                        n_max_out = n_absw[i];
                    end
                end
                n_state = BK_MUL;
            end
            BK_MUL: begin
                d_full = DIV_W'(r_max_out) << D_SHIFT;
                for (int i = 0; i < 4; i++) begin
                    n_rem[i]  = DIV_W'({r_absw[i], 1'b0}) * DIV_W'(r_max_axis) + d_full;
                    n_quot[i] = '0;
                end
                // Divisor is twice d, aligned to the top quotient bit.
                n_den   = d_full << QUOT_W;
                n_zero  = (r_max_axis == '0) || (r_max_out == '0);
                n_cnt   = '0;
                n_state = BK_DIV;
            end
            BK_DIV: begin
                for (int i = 0; i < 4; i++) begin
                    rem_t = r_rem[i];
                    q_t   = r_quot[i];
                    den_t = r_den;
                    for (int k = 0; k < DIV_PER_CYC; k++) begin
                        if (rem_t >= den_t) begin
                            rem_t = rem_t - den_t;
                            q_t   = {q_t[QUOT_W-2:0], 1'b1};
                        end else begin
                            q_t   = {q_t[QUOT_W-2:0], 1'b0};
                        end
                        den_t = den_t >> 1;
                    end
                    n_rem[i]  = rem_t;
                    n_quot[i] = q_t;
                    if (r_zero) begin
                        spd[i] = '0;
                    end else if (r_negw[i]) begin
                        spd[i] = q_t > QUOT_W'(32768) ? -16'sd32768 : -16'(q_t);
                    end else begin
                        spd[i] = q_t > QUOT_W'(32767) ? 16'sd32767 : 16'(q_t);
                    end
                end
                n_den = den_t;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_CYCLES - 1)) begin
                    n_out.front_left_speed  = spd[0];
                    n_out.back_left_speed   = spd[1];
                    n_out.front_right_speed = spd[2];
                    n_out.back_right_speed  = spd[3];
                    n_strobe = 1'b1;
                    n_state  = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    assign o_status.idle = (r_state == BK_IDLE);
    assign o_status.pop  = pop;
    assign o_strobe      = r_strobe;
    assign o_result      = r_out;

endmodule

[src/field_centric_xdrive_mixer.sv]
// ---------------------------------------------------------------------------
// field_centric_xdrive_mixer
// Field-centric X-drive mixer: stick axes and heading in, four wheel speeds out.
// ---------------------------------------------------------------------------
//  Channel   Ports                         Handshake
//  --------  ----------------------------  ------------------------------------
//  input     i_start, o_busy, i_item       word taken when i_start && !o_busy
//  result    o_strobe, o_result            word valid for the single strobe cycle
//
// Each word passes through the back end in order: a load, the CORDIC
// rotation at four micro-rotations per cycle, a scale multiply, a mix, a
// numerator multiply and the two-bit-per-cycle divider for the wheel scaling.
// The back end works on one word at a time and takes no new one until it
// is done; a two-deep queue lets the front take words while it is working.
// Reset is synchronous and active low; it empties the queue and idles the
// back end. The receiver cannot stall, so results leave as soon as they are done.
// ---------------------------------------------------------------------------
module field_centric_xdrive_mixer #(
    parameter int FRAC_BITS = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  fcxm_pkg::t_in  i_item,
    output logic           o_busy,
    output logic           o_strobe,
    output fcxm_pkg::t_out o_result
);
    import fcxm_pkg::*;

    `include "field_centric_xdrive_mixer_assert.svh"

    t_job         front_job;
    t_job         queue_job;
    t_q_status    q_status;
    t_back_status back_status;
    logic         push;

    // The front end is purely combinational: curve lookups and the heading
    // fold happen in the accepting cycle, and the result lands in the queue.
    fcxm_front u_front (
        .i_item (i_item),
        .o_job  (front_job)
    );

    assign push   = i_start && !o_busy;
    assign o_busy = q_status.full;

    fcxm_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (front_job),
        .i_pop    (back_status.pop),
        .o_job    (queue_job),
        .o_status (q_status)
    );

    // The back end pops a word whenever it is idle and the queue holds one.
    fcxm_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_job      (queue_job),
        .o_status   (back_status),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

    // A pop never happens on an empty queue.
    `FCXM_ASSERT_IMP(a_pop_nonempty, i_clk, i_rst_n, back_status.pop, !q_status.empty)
    // An accepted word is in the queue or already taken by the back end.
    `FCXM_ASSERT_NXT(a_push_lands, i_clk, i_rst_n, push, !q_status.empty || !back_status.idle)
    // With nothing queued and the back end idle, no result can appear.
    `FCXM_ASSERT_NXT(a_no_spurious, i_clk, i_rst_n, q_status.empty && back_status.idle, !o_strobe)

endmodule

[tb/tb_field_centric_xdrive_mixer.sv]
// ---------------------------------------------------------------------------
// tb_field_centric_xdrive_mixer
// Self-checking bench for the field-centric X-drive mixer. Stick and heading
// words are driven through the start/busy handshake. A scoreboard computes
// the four wheel speeds for each accepted word and checks the strobed results
// against them in order.
// ---------------------------------------------------------------------------
module tb_field_centric_xdrive_mixer;
    timeunit 1ns;
    timeprecision 1ps;

    import fcxm_pkg::*;

    localparam int FRAC = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 40;

    // The wheel-speed predictor and the queue of expected wheel words.
    class wheel_scoreboard;
        t_out pending[$];
        int   mismatches;

        // Signed curve: floor(sqrt(floor(|v|^3 * 2^32 / div))), sign of v kept.
        function automatic longint curve(longint v, longint div);
            longint unsigned a, x, r, b;
            a = v < 0 ? -v : v;
            x = ((a * a * a) << 32) / div;
            r = 0;
            b = 64'h4000_0000_0000_0000;
            while (b != 0) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return v < 0 ? -longint'(r) : longint'(r);
        endfunction

        function automatic longint absl(longint v);
            return v < 0 ? -v : v;
        endfunction

        // Compute the expected wheels for one accepted stick word.
        function void note_word(t_in w);
            longint jx, jy, jz, u, v, g, z, du, dv, x2, y2, max_axis, max_out, d, q, r;
            longint wh[4];
            longint atan_steps[16];
            logic signed [15:0] spd[4];
            t_out res;
            atan_steps = '{1152000, 680065, 359328, 182400, 91554, 45822, 22916,
                           11459, 5730, 2865, 1432, 716, 358, 179, 90, 45};
            jx = curve(-longint'(w.strafe_axis), 100);
            jy = curve(longint'(w.forward_axis), 100);
            // Halving truncates toward zero, as SystemVerilog division does.
            jz = curve(longint'(w.turn_axis) / 2, 50);
            u = jy;
            v = jx;
            g = longint'(w.heading_centideg);
            if (g >= 36000) g -= 36000;
            if (g > 18000) g -= 36000;
            // Fold the angle into +-90 degrees so the rotation converges.
            if (g > 9000) begin
                u = -u; v = -v; g -= 18000;
            end else if (g < -9000) begin
                u = -u; v = -v; g += 18000;
            end
            z = g * 256;
            for (int i = 0; i < 16; i++) begin
                du = v >>> i;
                dv = u >>> i;
                if (z >= 0) begin
                    u -= du; v += dv; z -= atan_steps[i];
                end else begin
                    u += du; v -= dv; z += atan_steps[i];
                end
            end
            x2 = (u * 28141 + 32768) >>> 16;
            y2 = (v * 28141 + 32768) >>> 16;
            wh[0] = x2 - y2 + jz;
            wh[1] = x2 + y2 + jz;
            wh[2] = -x2 - y2 + jz;
            wh[3] = -x2 + y2 + jz;
            max_axis = absl(jx);
            if (absl(jy) > max_axis) max_axis = absl(jy);
            if (absl(jz) > max_axis) max_axis = absl(jz);
            max_out = 0;
            for (int i = 0; i < 4; i++)
                if (absl(wh[i]) > max_out) max_out = absl(wh[i]);
            for (int i = 0; i < 4; i++) begin
                r = 0;
                // A zero maximum on either side forces all wheels to zero.
                if (max_axis != 0 && max_out != 0) begin
                    d = max_out << (16 - FRAC);
                    q = (2 * absl(wh[i]) * max_axis + d) / (2 * d);
                    if (wh[i] < 0) r = q > 32768 ? -32768 : -q;
                    else r = q > 32767 ? 32767 : q;
                end
                spd[i] = 16'(r);
            end
            res.front_left_speed  = spd[0];
            res.back_left_speed   = spd[1];
            res.front_right_speed = spd[2];
            res.back_right_speed  = spd[3];
            pending.push_back(res);
        endfunction

        // Compare one strobed result with the oldest expected word.
        function void check_word(t_out got);
            t_out want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result word %h", got);
                return;
            end
            want = pending.pop_front();
            if (got.front_left_speed !== want.front_left_speed ||
                got.back_left_speed !== want.back_left_speed ||
                got.front_right_speed !== want.front_right_speed ||
                got.back_right_speed !== want.back_right_speed) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"ERROR: wheels FL/BL/FR/BR expected %0d %0d %0d %0d",
                              " got %0d %0d %0d %0d"},
                             want.front_left_speed, want.back_left_speed,
                             want.front_right_speed, want.back_right_speed,
                             got.front_left_speed, got.back_left_speed,
                             got.front_right_speed, got.back_right_speed);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    t_in  i_item = '0;
    logic o_busy;
    logic o_strobe;
    t_out o_result;

    wheel_scoreboard wheels = new();
    int idle_pct = 0;
    int quiet_cycles = 0;

    field_centric_xdrive_mixer #(.FRAC_BITS(FRAC)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_item(i_item),
        .o_busy(o_busy), .o_strobe(o_strobe), .o_result(o_result)
    );

    always #6 i_clk = ~i_clk;

    // Sample at the rising edge: note accepted words, check strobed results,
    // and count cycles with no traffic for the watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_start && !o_busy) wheels.note_word(i_item);
            if (o_strobe) wheels.check_word(o_result);
            if ((i_start && !o_busy) || o_strobe) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("field_centric_xdrive_mixer verification failed");
                $finish;
            end
        end
    end

    // Present one word at a falling edge, optionally after random idle
    // cycles, and hold it until the block takes it. Start stays high across
    // back-to-back words so it is never lowered and raised in one step.
    task automatic send_word(t_in w);
        if (idle_pct > 0) begin
            while ($urandom_range(99) < idle_pct) begin
                i_start <= 1'b0;
                @(negedge i_clk);
            end
        end
        i_start <= 1'b1;
        i_item  <= w;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_sticks(int sx, int fy, int tz, int hd);
        t_in w;
        w.strafe_axis      = 8'(sx);
        w.forward_axis     = 8'(fy);
        w.turn_axis        = 8'(tz);
        w.heading_centideg = 16'(hd);
        send_word(w);
    endtask

    // Mostly in-range sticks and headings, with some full-width noise.
    function automatic t_in random_sticks();
        t_in w;
        if ($urandom_range(9) < 8) begin
            w.strafe_axis      = 8'($urandom_range(200) - 100);
            w.forward_axis     = 8'($urandom_range(200) - 100);
            w.turn_axis        = 8'($urandom_range(200) - 100);
            w.heading_centideg = 16'($urandom_range(35999));
            if ($urandom_range(7) == 0) w.strafe_axis = '0;
            if ($urandom_range(7) == 0) w.turn_axis = '0;
        end else begin
            w = t_in'(40'({$urandom(), $urandom()}));
        end
        return w;
    endfunction

    task automatic wait_drained();
        i_start <= 1'b0;
        while (wheels.pending.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        int phase_pct[4];
        // The receiver cannot stall, so the phases vary only sender idling; two run without it.
        phase_pct = '{0, 61, 0, 15};
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: all-zero sticks, full deflection, out-of-range values,
        // turn-only, quarter and half headings, and headings past one turn.
        send_sticks(0, 0, 0, 0);
        send_sticks(0, 0, 0, 12345);
        send_sticks(100, 0, 0, 0);
        send_sticks(-100, 0, 0, 0);
        send_sticks(0, 100, 0, 9000);
        send_sticks(0, -100, 0, 18000);
        send_sticks(0, 0, 100, 0);
        send_sticks(0, 0, -100, 27000);
        send_sticks(0, 0, 1, 0);
        send_sticks(0, 0, -1, 500);
        send_sticks(100, 100, 100, 4500);
        send_sticks(-100, -100, -100, 35999);
        send_sticks(127, -128, 127, 0);
        send_sticks(-128, 127, -128, 9001);
        send_sticks(50, -30, 20, 36000);
        send_sticks(-7, 80, -60, 65535);
        send_sticks(1, 1, 0, 17999);
        send_sticks(-1, 0, 3, 18001);
        send_sticks(60, 60, -100, 8999);
        send_sticks(0, 100, 100, 50000);

        // Sender pause until every expected word is back.
        wait_drained();
        @(negedge i_clk);

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = phase_pct[ph];
            for (int n = 0; n < 350; n++) send_word(random_sticks());
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (wheels.mismatches == 0 && wheels.pending.size() == 0) begin
            $display("field_centric_xdrive_mixer verification clean");
        end else begin
            $display("field_centric_xdrive_mixer verification failed");
        end
        $finish;
    end
endmodule

[sim.f]
+incdir+src
src/fcxm_pkg.sv
src/fcxm_front.sv
src/fcxm_queue.sv
src/fcxm_back.sv
src/field_centric_xdrive_mixer.sv
tb/tb_field_centric_xdrive_mixer.sv
